/* rtl/spp_pkg.sv */
// spp_pkg: shared types, codes and constants for the setpoint profile generator
// no dependencies; used by every rtl file of the block but spp_muldiv
package spp_pkg;

   localparam int MAX_SEGMENTS_DEF = 32;
   localparam logic [15:0] MS_PER_UNIT_RESET = 16'd2000;
   localparam int FRAC_BITS = 8;

   localparam logic [2:0] MODE_CLEAR   = 3'd0;
   localparam logic [2:0] MODE_APPEND  = 3'd1;
   localparam logic [2:0] MODE_COMMIT  = 3'd2;
   localparam logic [2:0] MODE_RESTART = 3'd3;
   localparam logic [2:0] MODE_TICK    = 3'd4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [11:0] seg_target;
      logic [31:0] seg_time_ms;
      logic [31:0] now_ms;
   } spp_req_type;

   typedef struct packed {
      logic [19:0] setpoint_q8;
      logic        running;
      logic [5:0]  segment_now;
      logic        ramping_down;
      logic        finished;
      logic        stretched;
   } spp_rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_APPEND,
      CMD_RESTART,
      CMD_WALK_INIT,
      CMD_READ_WALK,
      CMD_SUM_ACC,
      CMD_UNITS,
      CMD_MIN,
      CMD_STR_INIT,
      CMD_STR_GO,
      CMD_STR_WR,
      CMD_ARM,
      CMD_TICK_RD,
      CMD_TICK_GO,
      CMD_TICK_NEXT,
      CMD_TICK_WR,
      CMD_DOWN_MUL,
      CMD_DOWN_GO,
      CMD_DOWN_WR,
      CMD_DOWN_END,
      CMD_RSP
   } spp_cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       armed;
      logic       in_segment;
      logic       walk_last;
      logic       count_zero;
      logic       stretch_need;
      logic       e_lt_time;
      logic       e_lt_down;
      logic       md_busy;
      logic       rsp_free;
   } spp_status_type;

endpackage

/* rtl/piecewise_setpoint_profile_top.sv */
// piecewise_setpoint_profile_top: setpoint ramp generator, one result transfer per request
// clear, append, restart and idle tick go straight to the result; a tick inside a ramp or ramp-down
//   uses the shared multiply/divide unit (32 multiply steps then 66 divide steps)
// commit: sums the segments, then rescales each segment's time in that unit when times stretch
// one request at a time; the next is taken while a result still waits
// reset (synchronous, active high): table empty, stopped, setpoint 0, ms_per_unit 2000
module piecewise_setpoint_profile_top #(
   parameter int MAX_SEGMENTS = spp_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spp_pkg::spp_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spp_pkg::spp_rsp_type  rsp_data,
   input  logic                  csr_write_en,
   input  logic [15:0]           csr_write_data
);

   spp_pkg::spp_cmd_type    cmd;
   spp_pkg::spp_status_type status;

   spp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spp_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data       (req_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

endmodule

/* rtl/spp_muldiv.sv */
// spp_muldiv: iterative floor(a * b / d), shift-add multiply then restoring divide
// depends on nothing outside itself; used by spp_datapath
module spp_muldiv #(
   parameter int A_WIDTH = 34,
   parameter int D_WIDTH = 37
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [A_WIDTH-1:0]      a,
   input  logic [31:0]             b,
   input  logic [D_WIDTH-1:0]      d,
   output logic                    busy,
   output logic [A_WIDTH+31:0]     quotient
);

   localparam int PW = A_WIDTH + 32;
   localparam int CNTW = $clog2(PW);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL,
      PH_DIV
   } phase_type;

   phase_type            phase_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic [A_WIDTH-1:0]   a_ff;
   logic [31:0]          b_ff;
   logic [D_WIDTH-1:0]   d_ff;
   logic [PW-1:0]        acc_ff;
   logic [D_WIDTH:0]     rem_ff;

   logic [D_WIDTH:0]     rem_shift;
   logic [D_WIDTH:0]     rem_sub;
   logic                 rem_ge;
   logic [PW-1:0]        mul_sum;

   assign rem_shift = {rem_ff[D_WIDTH-1:0], acc_ff[PW-1]};
   assign rem_ge    = rem_shift >= {1'b0, d_ff};
   assign rem_sub   = rem_shift - {1'b0, d_ff};
   assign mul_sum   = {acc_ff[PW-2:0], 1'b0} + (b_ff[31] ? PW'(a_ff) : {PW{1'b0}});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  a_ff     <= a;
                  b_ff     <= b;
                  d_ff     <= d;
                  acc_ff   <= '0;
                  rem_ff   <= '0;
                  cnt_ff   <= CNTW'(31);
                  phase_ff <= PH_MUL;
               end
            end
            PH_MUL: begin
               acc_ff <= mul_sum;
               b_ff   <= {b_ff[30:0], 1'b0};
               if (cnt_ff == '0) begin
                  cnt_ff   <= CNTW'(PW - 1);
                  phase_ff <= PH_DIV;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            PH_DIV: begin
               rem_ff <= rem_ge ? rem_sub : rem_shift;
               acc_ff <= {acc_ff[PW-2:0], rem_ge};
               if (cnt_ff == '0) begin
                  phase_ff <= PH_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign busy     = (phase_ff != PH_IDLE);
   assign quotient = acc_ff;

endmodule

/* rtl/spp_datapath.sv */
// spp_datapath: segment tables, profile state, commit sums and output register
// depends on spp_pkg and spp_muldiv; driven by commands from spp_ctrl
module spp_datapath #(
   parameter int MAX_SEGMENTS = spp_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spp_pkg::spp_cmd_type     cmd,
   output spp_pkg::spp_status_type  status,
   input  spp_pkg::spp_req_type     req_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output spp_pkg::spp_rsp_type     rsp_data,
   input  logic                     csr_write_en,
   input  logic [15:0]              csr_write_data
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int UW = 12 + $clog2(MAX_SEGMENTS + 1);
   localparam int MW = UW + 16;
   localparam int DW = 32 + $clog2(MAX_SEGMENTS + 1);
   localparam int PW = MW + 32;
   localparam int XW = (MW > DW) ? MW : DW;

   logic [11:0]          tgt_mem [MAX_SEGMENTS];
   logic [31:0]          time_mem [MAX_SEGMENTS];

   spp_pkg::spp_req_type req_ff;
   logic [15:0]          ms_ff;
   logic [CW-1:0]        seg_count_ff;
   logic                 armed_ff;
   logic [CW-1:0]        seg_idx_ff;
   logic [11:0]          start_ff;
   logic [31:0]          seg_start_ff;
   logic [19:0]          held_ff;
   logic [31:0]          e_ff;
   logic [CW-1:0]        walk_ff;
   logic [UW-1:0]        units_ff;
   logic [DW-1:0]        user_ff;
   logic [11:0]          prev_ff;
   logic [MW-1:0]        min_ff;
   logic [27:0]          down_ff;
   logic                 up_ff;
   logic [11:0]          tgt_rd_ff;
   logic [31:0]          time_rd_ff;
   logic                 stretched_ff;
   logic                 finished_ff;
   logic                 rsp_valid_ff;
   spp_pkg::spp_rsp_type rsp_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 tgt_we;
   logic                 time_we;
   logic [AW-1:0]        wr_addr;
   logic [31:0]          time_wdata;
   logic                 md_start;
   logic [MW-1:0]        md_a;
   logic [31:0]          md_b;
   logic [DW-1:0]        md_d;
   logic                 md_busy;
   logic [PW-1:0]        md_q;
   logic [31:0]          sat_q;
   logic [11:0]          walk_diff;
   logic [11:0]          seg_diff;
   logic [19:0]          base_q8;

   assign sat_q     = (|md_q[PW-1:32]) ? 32'hFFFF_FFFF : md_q[31:0];
   assign walk_diff = (tgt_rd_ff > prev_ff) ? (tgt_rd_ff - prev_ff) : (prev_ff - tgt_rd_ff);
   assign seg_diff  = (tgt_rd_ff > start_ff) ? (tgt_rd_ff - start_ff)
                                             : (start_ff - tgt_rd_ff);
   assign base_q8   = {start_ff, 8'b0};

   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = walk_ff[AW-1:0];
      tgt_we     = 1'b0;
      time_we    = 1'b0;
      wr_addr    = seg_count_ff[AW-1:0];
      time_wdata = req_ff.seg_time_ms;
      md_start   = 1'b0;
      md_a       = MW'(base_q8);
      md_b       = e_ff;
      md_d       = DW'(down_ff);
      case (cmd)
         spp_pkg::CMD_APPEND: begin
            if (seg_count_ff < CW'(MAX_SEGMENTS)) begin
               tgt_we  = 1'b1;
               time_we = 1'b1;
            end
         end
         spp_pkg::CMD_READ_WALK: begin
            rd_en = 1'b1;
         end
         spp_pkg::CMD_TICK_RD: begin
            rd_en   = 1'b1;
            rd_addr = seg_idx_ff[AW-1:0];
         end
         spp_pkg::CMD_STR_GO: begin
            md_start = 1'b1;
            md_a     = min_ff;
            md_b     = time_rd_ff;
            md_d     = user_ff;
         end
         spp_pkg::CMD_STR_WR: begin
            time_we    = 1'b1;
            wr_addr    = walk_ff[AW-1:0];
            time_wdata = sat_q;
         end
         spp_pkg::CMD_TICK_GO: begin
            md_start = 1'b1;
            md_a     = MW'({seg_diff, 8'b0});
            md_d     = DW'(time_rd_ff);
         end
         spp_pkg::CMD_DOWN_GO: begin
            md_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[wr_addr] <= req_ff.seg_target;
      end
      if (rd_en) begin
         tgt_rd_ff <= tgt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[wr_addr] <= time_wdata;
      end
      if (rd_en) begin
         time_rd_ff <= time_mem[rd_addr];
      end
   end

   spp_muldiv #(
      .A_WIDTH (MW),
      .D_WIDTH (DW)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .a        (md_a),
      .b        (md_b),
      .d        (md_d),
      .busy     (md_busy),
      .quotient (md_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff        <= spp_pkg::MS_PER_UNIT_RESET;
         seg_count_ff <= '0;
         armed_ff     <= 1'b0;
         seg_idx_ff   <= '0;
         start_ff     <= '0;
         seg_start_ff <= '0;
         held_ff      <= '0;
         stretched_ff <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            ms_ff <= csr_write_data;
         end
         if (cmd == spp_pkg::CMD_RSP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd)
            spp_pkg::CMD_LOAD: begin
               req_ff       <= req_data;
               e_ff         <= req_data.now_ms - seg_start_ff;
               stretched_ff <= 1'b0;
               finished_ff  <= 1'b0;
            end
            spp_pkg::CMD_CLEAR: begin
               seg_count_ff <= '0;
               armed_ff     <= 1'b0;
            end
            spp_pkg::CMD_APPEND: begin
               if (seg_count_ff < CW'(MAX_SEGMENTS)) begin
                  seg_count_ff <= seg_count_ff + 1'b1;
               end
            end
            spp_pkg::CMD_RESTART: begin
               seg_idx_ff   <= '0;
               start_ff     <= '0;
               seg_start_ff <= req_ff.now_ms;
            end
            spp_pkg::CMD_WALK_INIT: begin
               walk_ff  <= '0;
               units_ff <= '0;
               user_ff  <= '0;
               prev_ff  <= '0;
            end
            spp_pkg::CMD_SUM_ACC: begin
               units_ff <= units_ff + UW'(walk_diff);
               prev_ff  <= tgt_rd_ff;
               user_ff  <= user_ff + DW'(time_rd_ff);
               walk_ff  <= walk_ff + 1'b1;
            end
            spp_pkg::CMD_UNITS: begin
               units_ff <= units_ff + UW'(prev_ff);
            end
            spp_pkg::CMD_MIN: begin
               min_ff <= units_ff * ms_ff;
            end
            spp_pkg::CMD_STR_INIT: begin
               walk_ff      <= '0;
               stretched_ff <= 1'b1;
            end
            spp_pkg::CMD_STR_WR: begin
               walk_ff <= walk_ff + 1'b1;
            end
            spp_pkg::CMD_ARM: begin
               armed_ff     <= 1'b1;
               seg_idx_ff   <= '0;
               start_ff     <= '0;
               seg_start_ff <= req_ff.now_ms;
            end
            spp_pkg::CMD_TICK_GO: begin
               up_ff <= tgt_rd_ff > start_ff;
            end
            spp_pkg::CMD_TICK_NEXT: begin
               held_ff      <= {tgt_rd_ff, 8'b0};
               start_ff     <= tgt_rd_ff;
               seg_idx_ff   <= seg_idx_ff + 1'b1;
               seg_start_ff <= req_ff.now_ms;
            end
            spp_pkg::CMD_TICK_WR: begin
               held_ff <= up_ff ? (base_q8 + md_q[19:0]) : (base_q8 - md_q[19:0]);
            end
            spp_pkg::CMD_DOWN_MUL: begin
               down_ff <= start_ff * ms_ff;
            end
            spp_pkg::CMD_DOWN_WR: begin
               held_ff <= base_q8 - md_q[19:0];
            end
            spp_pkg::CMD_DOWN_END: begin
               held_ff     <= '0;
               armed_ff    <= 1'b0;
               finished_ff <= 1'b1;
            end
            spp_pkg::CMD_RSP: begin
               rsp_ff.setpoint_q8  <= held_ff;
               rsp_ff.running      <= armed_ff;
               rsp_ff.segment_now  <= 6'(seg_idx_ff);
               rsp_ff.ramping_down <= armed_ff && (seg_idx_ff >= seg_count_ff);
               rsp_ff.finished     <= finished_ff;
               rsp_ff.stretched    <= stretched_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.mode         = req_ff.mode;
   assign status.armed        = armed_ff;
   assign status.in_segment   = seg_idx_ff < seg_count_ff;
   assign status.walk_last    = (walk_ff == seg_count_ff - 1'b1);
   assign status.count_zero   = (seg_count_ff == '0);
   assign status.stretch_need = (user_ff != '0) && (XW'(user_ff) < XW'(min_ff));
   assign status.e_lt_time    = e_ff < time_rd_ff;
   assign status.e_lt_down    = e_ff < {4'b0, down_ff};
   assign status.md_busy      = md_busy;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count above table depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> seg_idx_ff <= seg_count_ff)
      else $error("segment index past count while running");

   a_fin_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.finished |-> !rsp_ff.running)
      else $error("finished transfer still running");

   a_str_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stretched |-> rsp_ff.running)
      else $error("stretched commit did not arm");

endmodule

/* rtl/spp_ctrl.sv */
// spp_ctrl: sequencing state machine, issues the datapath one command per cycle,
// CMD_NONE in wait states; depends on spp_pkg; reads status from spp_datapath
module spp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  spp_pkg::spp_status_type  status,
   output spp_pkg::spp_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_UNITS,
      ST_MIN,
      ST_CHK,
      ST_STR_RD,
      ST_STR_GO,
      ST_STR_WAIT,
      ST_ARM,
      ST_TICK_CHK,
      ST_TICK_WAIT,
      ST_DOWN_CHK,
      ST_DOWN_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = spp_pkg::CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = spp_pkg::CMD_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            case (status.mode)
               spp_pkg::MODE_CLEAR: begin
                  cmd = spp_pkg::CMD_CLEAR;
               end
               spp_pkg::MODE_APPEND: begin
                  cmd = spp_pkg::CMD_APPEND;
               end
               spp_pkg::MODE_RESTART: begin
                  cmd = spp_pkg::CMD_RESTART;
               end
               spp_pkg::MODE_COMMIT: begin
                  cmd      = spp_pkg::CMD_WALK_INIT;
                  state_in = status.count_zero ? ST_UNITS : ST_SUM_RD;
               end
               spp_pkg::MODE_TICK: begin
                  if (status.armed && status.in_segment) begin
                     cmd      = spp_pkg::CMD_TICK_RD;
                     state_in = ST_TICK_CHK;
                  end else if (status.armed) begin
                     cmd      = spp_pkg::CMD_DOWN_MUL;
                     state_in = ST_DOWN_CHK;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SUM_RD: begin
            cmd      = spp_pkg::CMD_READ_WALK;
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd      = spp_pkg::CMD_SUM_ACC;
            state_in = status.walk_last ? ST_UNITS : ST_SUM_RD;
         end
         ST_UNITS: begin
            cmd      = spp_pkg::CMD_UNITS;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            cmd      = spp_pkg::CMD_MIN;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.stretch_need) begin
               cmd      = spp_pkg::CMD_STR_INIT;
               state_in = ST_STR_RD;
            end else begin
               state_in = ST_ARM;
            end
         end
         ST_STR_RD: begin
            cmd      = spp_pkg::CMD_READ_WALK;
            state_in = ST_STR_GO;
         end
         ST_STR_GO: begin
            cmd      = spp_pkg::CMD_STR_GO;
            state_in = ST_STR_WAIT;
         end
         ST_STR_WAIT: begin
            if (!status.md_busy) begin
               cmd      = spp_pkg::CMD_STR_WR;
               state_in = status.walk_last ? ST_ARM : ST_STR_RD;
            end
         end
         ST_ARM: begin
            cmd      = spp_pkg::CMD_ARM;
            state_in = ST_RESP;
         end
         ST_TICK_CHK: begin
            if (status.e_lt_time) begin
               cmd      = spp_pkg::CMD_TICK_GO;
               state_in = ST_TICK_WAIT;
            end else begin
               cmd      = spp_pkg::CMD_TICK_NEXT;
               state_in = ST_RESP;
            end
         end
         ST_TICK_WAIT: begin
            if (!status.md_busy) begin
               cmd      = spp_pkg::CMD_TICK_WR;
               state_in = ST_RESP;
            end
         end
         ST_DOWN_CHK: begin
            if (status.e_lt_down) begin
               cmd      = spp_pkg::CMD_DOWN_GO;
               state_in = ST_DOWN_WAIT;
            end else begin
               cmd      = spp_pkg::CMD_DOWN_END;
               state_in = ST_RESP;
            end
         end
         ST_DOWN_WAIT: begin
            if (!status.md_busy) begin
               cmd      = spp_pkg::CMD_DOWN_WR;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd      = spp_pkg::CMD_RSP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for piecewise_setpoint_profile_top
// a directed table, then random profile runs checked against a behavioral profile predictor
// depends on spp_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_top;
   import spp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   spp_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   spp_rsp_type rsp_data;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   piecewise_setpoint_profile_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // profile predictor state
   logic [11:0] level_tab[MAX_SEGMENTS_DEF];
   logic [31:0] dur_tab[MAX_SEGMENTS_DEF];
   int unsigned seg_count;
   int unsigned seg_idx;
   bit          armed;
   logic [11:0] start_lvl;
   logic [31:0] seg_start;
   logic [19:0] held_sp;
   logic [15:0] ms_unit;

   spp_rsp_type setpoint_q[$];
   int          errors;
   int          sent_items;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;

   typedef struct {
      spp_req_type req;
      int          reps;
      bit          typed;
      spp_rsp_type rsp;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic spp_rsp_type profile_step(spp_req_type r);
      spp_rsp_type o;
      logic [63:0] units;
      logic [63:0] min_total;
      logic [63:0] user_total;
      logic [63:0] base;
      logic [63:0] diff;
      logic [63:0] step;
      logic [127:0] quot;
      logic [31:0] e;
      logic [31:0] down;
      logic [11:0] prev;
      bit fin;
      bit str;
      fin = 0;
      str = 0;
      e = r.now_ms - seg_start;
      case (r.mode)
         MODE_CLEAR: begin
            seg_count = 0;
            armed = 0;
         end
         MODE_APPEND: begin
            if (seg_count < MAX_SEGMENTS_DEF) begin
               level_tab[seg_count] = r.seg_target;
               dur_tab[seg_count] = r.seg_time_ms;
               seg_count++;
            end
         end
         MODE_COMMIT: begin
            units = 0;
            user_total = 0;
            prev = 0;
            for (int i = 0; i < seg_count; i++) begin
               units += (level_tab[i] > prev) ? 64'(level_tab[i] - prev)
                                              : 64'(prev - level_tab[i]);
               prev = level_tab[i];
               user_total += 64'(dur_tab[i]);
            end
            units += 64'(prev);
            min_total = units * 64'(ms_unit);
            if (user_total != 0 && user_total < min_total) begin
               for (int i = 0; i < seg_count; i++) begin
                  quot = (128'(dur_tab[i]) * 128'(min_total)) / 128'(user_total);
                  dur_tab[i] = (quot > 128'h0FFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
               end
               str = 1;
            end
            armed = 1;
            seg_idx = 0;
            start_lvl = 0;
            seg_start = r.now_ms;
         end
         MODE_RESTART: begin
            seg_idx = 0;
            start_lvl = 0;
            seg_start = r.now_ms;
         end
         MODE_TICK: begin
            if (armed) begin
               base = 64'(start_lvl) << 8;
               if (seg_idx < seg_count) begin
                  if (e < dur_tab[seg_idx]) begin
                     diff = (level_tab[seg_idx] > start_lvl) ?
                            64'(level_tab[seg_idx] - start_lvl) :
                            64'(start_lvl - level_tab[seg_idx]);
                     step = ((diff << 8) * 64'(e)) / 64'(dur_tab[seg_idx]);
                     held_sp = (level_tab[seg_idx] > start_lvl) ? 20'(base + step)
                                                                : 20'(base - step);
                  end else begin
                     held_sp = {level_tab[seg_idx], 8'h00};
                     start_lvl = level_tab[seg_idx];
                     seg_idx++;
                     seg_start = r.now_ms;
                  end
               end else begin
                  down = 32'(start_lvl) * 32'(ms_unit);
                  if (e < down) begin
                     held_sp = 20'(base - (base * 64'(e)) / 64'(down));
                  end else begin
                     held_sp = 0;
                     armed = 0;
                     fin = 1;
                  end
               end
            end
         end
         default: ;
      endcase
      o.setpoint_q8 = held_sp;
      o.running = armed;
      o.segment_now = seg_idx[5:0];
      o.ramping_down = armed && (seg_idx >= seg_count);
      o.finished = fin;
      o.stretched = str;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAIL piecewise_setpoint_profile_top");
      $finish;
   end

   // result side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (setpoint_q.size() == 0) begin
            $display("%0t unexpected transfer got %p", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data !== setpoint_q[0]) begin
               $display("%0t mismatch expected %p got %p", $time, setpoint_q[0], rsp_data);
               errors++;
            end
            void'(setpoint_q.pop_front());
         end
      end
   end

   task automatic send_req(input spp_req_type r, input bit typed, input spp_rsp_type t);
      spp_rsp_type p;
      if ($urandom_range(99) < send_idle_pct) begin
         do begin
            req_valid <= 1'b0;
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      p = profile_step(r);
      setpoint_q.push_back(typed ? t : p);
      sent_items++;
   endtask

   task automatic send_op(input logic [2:0] m, input logic [11:0] tg, input logic [31:0] tm,
                          input logic [31:0] now);
      spp_req_type r;
      r.mode = m;
      r.seg_target = tg;
      r.seg_time_ms = tm;
      r.now_ms = now;
      send_req(r, 0, '0);
   endtask

   task automatic add_row(input logic [2:0] m, input logic [11:0] tg, input logic [31:0] tm,
                          input logic [31:0] now, input int reps, input bit typed,
                          input spp_rsp_type t);
      dir_row_type d;
      d.req.mode = m;
      d.req.seg_target = tg;
      d.req.seg_time_ms = tm;
      d.req.now_ms = now;
      d.reps = reps;
      d.typed = typed;
      d.rsp = t;
      dir_rows.push_back(d);
   endtask

   task automatic write_ms_unit(input logic [15:0] v);
      req_valid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ms_unit = v;
   endtask

   function automatic logic [11:0] pick_level();
      return ($urandom_range(99) < 80) ? 12'($urandom_range(0, 63))
                                       : 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [31:0] pick_dur();
      return ($urandom_range(99) < 70) ? 32'($urandom_range(0, 5000)) : 32'($urandom);
   endfunction

   task automatic run_profiles(input int stop_at);
      int kind;
      int nseg;
      int ticks;
      logic [31:0] now;
      while (sent_items < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_op(3'($urandom_range(0, 7)), 12'($urandom), $urandom, $urandom);
         end else begin
            if ($urandom_range(99) < 90) send_op(MODE_CLEAR, 12'($urandom), $urandom, $urandom);
            if (kind < 13) begin
               // full swing table, one long segment, so stretched times can saturate
               for (int i = 0; i < MAX_SEGMENTS_DEF; i++)
                  send_op(MODE_APPEND, (i % 2) ? 12'd0 : 12'd4095, (i == 0) ? 32'd1000 : 32'd0,
                          $urandom);
            end else begin
               nseg = (kind < 16) ? $urandom_range(33, 34) : $urandom_range(1, 6);
               for (int i = 0; i < nseg; i++)
                  send_op(MODE_APPEND, pick_level(), pick_dur(), $urandom);
            end
            now = $urandom;
            send_op(MODE_COMMIT, 12'($urandom), $urandom, now);
            ticks = 0;
            while (armed && ticks < 60) begin
               kind = $urandom_range(99);
               if (kind < 60) now += $urandom_range(0, 2000);
               else if (kind < 90) now += $urandom_range(0, 200000);
               else now += $urandom;
               kind = $urandom_range(99);
               if (kind < 5) send_op(MODE_RESTART, 12'($urandom), $urandom, now);
               else if (kind < 7) send_op(MODE_APPEND, pick_level(), pick_dur(), now);
               else if (kind < 8) send_op(MODE_COMMIT, 12'($urandom), $urandom, now);
               send_op(MODE_TICK, 12'($urandom), $urandom, now);
               ticks++;
            end
         end
      end
   endtask

   initial begin
      logic [15:0] phase_ms[4];
      int          phase_send[4];
      int          phase_recv[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      errors = 0;
      sent_items = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      seg_count = 0;
      seg_idx = 0;
      armed = 0;
      start_lvl = 0;
      seg_start = 0;
      held_sp = 0;
      ms_unit = MS_PER_UNIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_row(MODE_TICK, 12'd0, 32'd0, 32'd0, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(3'd5, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(3'd6, 12'd0, 32'd0, 32'd0, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(3'd7, 12'd1, 32'd1, 32'd1, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(MODE_RESTART, 12'd0, 32'd0, 32'd123, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(MODE_COMMIT, 12'd0, 32'd0, 32'd100, 1, 1, '{0, 1, 0, 1, 0, 0});
      add_row(MODE_TICK, 12'd0, 32'd0, 32'd100, 1, 1, '{0, 0, 0, 0, 1, 0});
      add_row(MODE_CLEAR, 12'd0, 32'd0, 32'd0, 1, 1, '{0, 0, 0, 0, 0, 0});
      add_row(MODE_APPEND, 12'd4095, 32'hFFFF_FFFF, 32'd0, 1, 0, '0);
      add_row(MODE_APPEND, 12'd0, 32'd0, 32'd0, 1, 0, '0);
      add_row(MODE_APPEND, 12'd1, 32'd1, 32'd0, 1, 0, '0);
      add_row(MODE_COMMIT, 12'd0, 32'd0, 32'hFFFF_FFF0, 1, 0, '0);
      add_row(MODE_TICK, 12'd0, 32'd0, 32'h7FFF_FFF0, 1, 0, '0);
      add_row(MODE_TICK, 12'd0, 32'd0, 32'hFFFF_FFEF, 1, 1, '{20'hFFF00, 1, 1, 0, 0, 0});
      add_row(MODE_TICK, 12'd0, 32'd0, 32'hFFFF_FFEF, 1, 1, '{0, 1, 2, 0, 0, 0});
      add_row(MODE_TICK, 12'd0, 32'd0, 32'hFFFF_FFEF, 1, 1, '{0, 1, 2, 0, 0, 0});
      add_row(MODE_TICK, 12'd0, 32'd0, 32'hFFFF_FFF0, 1, 1, '{256, 1, 3, 1, 0, 0});
      add_row(MODE_TICK, 12'd0, 32'd0, 32'hFFFF_FFF1, 1, 0, '0);
      add_row(MODE_RESTART, 12'd0, 32'd0, 32'd0, 1, 1, '{256, 1, 0, 0, 0, 0});
      add_row(MODE_CLEAR, 12'd0, 32'd0, 32'd0, 1, 0, '0);
      add_row(MODE_APPEND, 12'd100, 32'd1000, 32'd0, 33, 0, '0);
      add_row(MODE_COMMIT, 12'd0, 32'd0, 32'd0, 1, 0, '0);
      add_row(MODE_TICK, 12'd0, 32'd0, 32'd5, 1, 0, '0);
      add_row(MODE_CLEAR, 12'd0, 32'd0, 32'd0, 1, 0, '0);

      foreach (dir_rows[i])
         repeat (dir_rows[i].reps) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      phase_ms = '{16'hFFFF, 16'd1, 16'd2000, 16'($urandom_range(1, 65535))};
      phase_send = '{0, 84, 0, 14};
      phase_recv = '{0, 0, 84, 14};
      for (int ph = 0; ph < 4; ph++) begin
         write_ms_unit(phase_ms[ph]);
         send_idle_pct = phase_send[ph];
         recv_stall_pct = phase_recv[ph];
         if (ph == 0) hold_cycles = 400;
         run_profiles(sent_items + 350);
      end
      req_valid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("PASS piecewise_setpoint_profile_top");
      end else begin
         $display("FAIL piecewise_setpoint_profile_top");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/spp_pkg.sv
rtl/spp_muldiv.sv
rtl/spp_datapath.sv
rtl/spp_ctrl.sv
rtl/piecewise_setpoint_profile_top.sv
tb/tb_top.sv
